>>> rtl/core/stm_pkg.sv
// Shared types and constants for the sensor threshold monitor.
// Used by the front, queue, back and top-level modules; no dependencies.
package stm_pkg;

    localparam int VALUE_W    = 16;
    localparam int EXT_W      = 18;
    localparam int COUNT_W    = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int S_DATA_W   = 24;
    localparam int M_DATA_W   = 24;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W     = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W     = $clog2(QUEUE_DEPTH + 1);

    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_ERROR  = 1'b1;

    typedef logic [1:0] t_kind;
    localparam t_kind KIND_SAMPLE = 2'd0;
    localparam t_kind KIND_NAN    = 2'd1;
    localparam t_kind KIND_ERROR  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_WARNING_LEVEL      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CRITICAL_LEVEL     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD_ENABLES  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TRIGGER_HYSTERESIS = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PUBLISH_HYSTERESIS = 3'd4;

    typedef struct packed {
        t_kind                      kind;
        logic signed [VALUE_W-1:0] reading;
    } t_entry;

    typedef struct packed {
        logic signed [VALUE_W-1:0] warning_level;
        logic signed [VALUE_W-1:0] critical_level;
        logic [1:0]                 threshold_enables;
        logic [VALUE_W-1:0]         trigger_hysteresis;
        logic [VALUE_W-1:0]         publish_hysteresis;
    } t_cfg;

    typedef struct packed {
        logic available;
        logic functional;
        logic critical_alarm_changed;
        logic warning_alarm_changed;
        logic critical_alarm;
        logic warning_alarm;
        logic value_published;
        logic shown_valid;
        logic signed [VALUE_W-1:0] shown_value;
    } t_result;

endpackage

>>> rtl/core/stm_front.sv
// Front end: accepts input words and classifies each into sample, no-reading or error.
// Depends on stm_pkg; feeds stm_queue.
module stm_front (
    input  logic                        i_s_axis_tvalid,
    output logic                        o_s_axis_tready,
    input  logic [stm_pkg::S_DATA_W-1:0] i_s_axis_tdata,
    input  logic                        i_s_axis_tuser,
    input  logic                        i_q_full,
    output logic                        o_push,
    output stm_pkg::t_entry             o_entry
);
    import stm_pkg::*;

    logic reading_valid;

    assign reading_valid   = i_s_axis_tdata[VALUE_W];
    assign o_s_axis_tready = !i_q_full;
    assign o_push          = i_s_axis_tvalid && !i_q_full;

    always_comb begin
        o_entry.reading = '0;
        if (i_s_axis_tuser == CMD_ERROR) begin
            o_entry.kind = KIND_ERROR;
        end else if (reading_valid) begin
            o_entry.kind    = KIND_SAMPLE;
            o_entry.reading = i_s_axis_tdata[VALUE_W-1:0];
        end else begin
            o_entry.kind = KIND_NAN;
        end
    end

endmodule

>>> rtl/core/stm_queue.sv
// Short queue between the front end and the back end.
// Depends on stm_pkg.
module stm_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  stm_pkg::t_entry i_entry,
    input  logic            i_pop,
    output logic            o_full,
    output logic            o_valid,
    output stm_pkg::t_entry o_entry
);
    import stm_pkg::*;

    t_entry              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   r_head, n_head;
    logic [QPTR_W-1:0]   r_tail, n_tail;
    logic [QCNT_W-1:0]   r_count, n_count;
    logic                do_push;
    logic                do_pop;

    assign o_full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_entry = r_mem[r_head];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_head  = do_pop  ? r_head + 1'b1 : r_head;
        n_tail  = do_push ? r_tail + 1'b1 : r_tail;
        n_count = r_count + QCNT_W'(do_push) - QCNT_W'(do_pop);
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_tail] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
        end
    end

endmodule

>>> rtl/core/stm_back.sv
// Back end: configuration registers, sensor state, alarm update and output register.
// Depends on stm_pkg; drains stm_queue.
module stm_back #(
    parameter int ERROR_LIMIT = 5
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [stm_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [stm_pkg::VALUE_W-1:0]   i_cfg_data,
    input  logic                          i_q_valid,
    input  stm_pkg::t_entry               i_q_entry,
    output logic                          o_pop,
    output logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    output stm_pkg::t_result              o_result
);
    import stm_pkg::*;

    t_cfg                       r_cfg;
    logic signed [VALUE_W-1:0]  r_last, n_last;
    logic                       r_known, n_known;
    logic                       r_warn, n_warn;
    logic                       r_crit, n_crit;
    logic [COUNT_W-1:0]         r_count, n_count;
    logic                       r_func, n_func;
    logic                       r_out_valid;
    t_result                    r_out, n_out;

    logic signed [VALUE_W:0]    diff;
    logic [VALUE_W:0]           diff_mag;
    logic [COUNT_W-1:0]         count_inc;
    logic                       published;

    function automatic logic schmitt(
        input logic                      cur,
        input logic signed [VALUE_W-1:0] value,
        input logic signed [VALUE_W-1:0] level,
        input logic [VALUE_W-1:0]        hyst
    );
        logic signed [EXT_W-1:0] low_edge;
        logic                    res;
        low_edge = EXT_W'(level) - $signed({2'b00, hyst});
        if (value >= level) begin
            res = 1'b1;
        end else if (EXT_W'(value) < low_edge) begin
            res = 1'b0;
        end else begin
            res = cur;
        end
        return res;
    endfunction

    assign o_cfg_ready     = 1'b1;
    assign o_pop           = i_q_valid && (!r_out_valid || i_m_axis_tready);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_result        = r_out;

    assign diff      = (VALUE_W+1)'(r_last) - (VALUE_W+1)'(i_q_entry.reading);
    assign diff_mag  = diff[VALUE_W] ? unsigned'(-diff) : unsigned'(diff);
    assign count_inc = r_count + 1'b1;

    always_comb begin
        n_last    = r_last;
        n_known   = r_known;
        n_warn    = r_warn;
        n_crit    = r_crit;
        n_count   = r_count;
        n_func    = r_func;
        published = 1'b0;
        unique case (i_q_entry.kind)
            KIND_SAMPLE, KIND_NAN: begin
                if (i_q_entry.kind == KIND_SAMPLE) begin
                    if (!r_known || diff_mag > {1'b0, r_cfg.publish_hysteresis}) begin
                        n_last    = i_q_entry.reading;
                        n_known   = 1'b1;
                        published = 1'b1;
                    end
                end else begin
                    n_last    = '0;
                    n_known   = 1'b0;
                    published = 1'b1;
                end
                if (n_known && r_cfg.threshold_enables[0]) begin
                    n_warn = schmitt(r_warn, n_last, r_cfg.warning_level,
                                     r_cfg.trigger_hysteresis);
                end
                if (n_known && r_cfg.threshold_enables[1]) begin
                    n_crit = schmitt(r_crit, n_last, r_cfg.critical_level,
                                     r_cfg.trigger_hysteresis);
                end
                n_func  = (i_q_entry.kind == KIND_SAMPLE);
                n_count = '0;
            end
            default: begin
                if (r_count < COUNT_W'(ERROR_LIMIT)) begin
                    n_count = count_inc;
                    if (count_inc == COUNT_W'(ERROR_LIMIT)) begin
                        n_last    = '0;
                        n_known   = 1'b0;
                        published = 1'b1;
                        n_func    = 1'b0;
                        n_count   = '0;
                    end
                end
            end
        endcase

        n_out.shown_value            = n_last;
        n_out.shown_valid            = n_known;
        n_out.value_published        = published;
        n_out.warning_alarm          = n_warn;
        n_out.critical_alarm         = n_crit;
        n_out.warning_alarm_changed  = n_warn ^ r_warn;
        n_out.critical_alarm_changed = n_crit ^ r_crit;
        n_out.functional             = n_func;
        n_out.available              = n_func;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.warning_level      <= 16'sh7FFF;
            r_cfg.critical_level     <= 16'sh7FFF;
            r_cfg.threshold_enables  <= '0;
            r_cfg.trigger_hysteresis <= '0;
            r_cfg.publish_hysteresis <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_WARNING_LEVEL:      r_cfg.warning_level      <= i_cfg_data;
                CFG_CRITICAL_LEVEL:     r_cfg.critical_level     <= i_cfg_data;
                CFG_THRESHOLD_ENABLES:  r_cfg.threshold_enables  <= i_cfg_data[1:0];
                CFG_TRIGGER_HYSTERESIS: r_cfg.trigger_hysteresis <= i_cfg_data;
                CFG_PUBLISH_HYSTERESIS: r_cfg.publish_hysteresis <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last      <= '0;
            r_known     <= 1'b0;
            r_warn      <= 1'b0;
            r_crit      <= 1'b0;
            r_count     <= '0;
            r_func      <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_last  <= n_last;
                r_known <= n_known;
                r_warn  <= n_warn;
                r_crit  <= n_crit;
                r_count <= n_count;
                r_func  <= n_func;
            end
            if (o_pop) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_out <= n_out;
        end
    end

endmodule

>>> rtl/core/sensor_threshold_monitor_core.sv
// Sensor threshold monitor top level: front end, queue and back end.
// Depends on stm_pkg, stm_front, stm_queue and stm_back.
//
// Takes one word per cycle while the queue is not full: a temperature
// sample (signed Q8.8 with a valid flag) or a read-error event, and
// returns one result word per input word, in order. The front end
// classifies each word into a four-entry queue; the back end updates the
// published value, the warning and critical Schmitt-trigger alarms and
// the status flags for each word and holds the result in an output
// register. A word passes through the queue and then the output register
// before its result appears; the sustained rate is one word per cycle
// while the output side accepts results. Configuration writes are taken
// every cycle and must happen only while no word is in flight.
module sensor_threshold_monitor_core #(
    parameter int ERROR_LIMIT = 5
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [stm_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [stm_pkg::VALUE_W-1:0]   i_cfg_data,
    input  logic                          i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    // [15:0] reading, [16] reading_valid, [23:17] zero
    input  logic [stm_pkg::S_DATA_W-1:0]  i_s_axis_tdata,
    // [0] cmd
    input  logic                          i_s_axis_tuser,
    output logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    // [15:0] shown_value, [16] shown_valid, [17] value_published,
    // [18] warning_alarm, [19] critical_alarm, [20] warning_alarm_changed,
    // [21] critical_alarm_changed, [22] functional, [23] available
    output logic [stm_pkg::M_DATA_W-1:0]  o_m_axis_tdata
);
    import stm_pkg::*;

    logic    q_full;
    logic    q_valid;
    logic    push;
    logic    pop;
    t_entry  front_entry;
    t_entry  head_entry;
    t_result result;

    stm_front u_front (
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .i_q_full        (q_full),
        .o_push          (push),
        .o_entry         (front_entry)
    );

    stm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (front_entry),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_entry (head_entry)
    );

    stm_back #(
        .ERROR_LIMIT (ERROR_LIMIT)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_q_valid       (q_valid),
        .i_q_entry       (head_entry),
        .o_pop           (pop),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_result        (result)
    );

    assign o_m_axis_tdata = M_DATA_W'(result);

endmodule

>>> sim/tb_sensor_threshold_monitor_core.sv
// Self-checking testbench for sensor_threshold_monitor_core: drives samples and error
// events through the input stream with random gaps and back-pressure, and checks
// every result word against an in-bench predictor. Depends on stm_pkg and the core.
module tb_sensor_threshold_monitor_core;

    import stm_pkg::*;

    localparam int ERR_LIMIT    = 5;
    localparam int LIMIT_CYCLES = 1000000;
    localparam int MAX_REPORTS  = 50;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [VALUE_W-1:0]   cfg_data = '0;
    logic                 s_valid = 1'b0;
    logic [S_DATA_W-1:0]  s_data = '0;
    logic                 s_user = 1'b0;
    logic                 m_ready = 1'b0;

    logic                 o_cfg_ready;
    logic                 o_s_axis_tready;
    logic                 o_m_axis_tvalid;
    logic [M_DATA_W-1:0]  o_m_axis_tdata;

    sensor_threshold_monitor_core #(
        .ERROR_LIMIT(ERR_LIMIT)
    ) i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data),
        .i_s_axis_tvalid(s_valid),
        .o_s_axis_tready(o_s_axis_tready),
        .i_s_axis_tdata (s_data),
        .i_s_axis_tuser (s_user),
        .o_m_axis_tvalid(o_m_axis_tvalid),
        .i_m_axis_tready(m_ready),
        .o_m_axis_tdata (o_m_axis_tdata)
    );

    // predictor configuration and state
    logic signed [VALUE_W-1:0] warn_lvl = 16'sh7fff;
    logic signed [VALUE_W-1:0] crit_lvl = 16'sh7fff;
    logic [1:0]                alarm_en = 2'b00;
    logic [VALUE_W-1:0]        trig_hyst = '0;
    logic [VALUE_W-1:0]        pub_hyst = '0;

    logic signed [VALUE_W-1:0] stored_val = '0;
    bit                        val_known = 1'b0;
    bit                        warn_on = 1'b0;
    bit                        crit_on = 1'b0;
    logic [COUNT_W-1:0]        err_cnt = '0;
    bit                        func_flag = 1'b1;
    bit                        avail_flag = 1'b1;

    t_result pending_results[$];
    t_result res_seen;
    t_result res_want;

    bit steady = 1'b0;
    int rx_hold = 0;
    int cycle_cnt = 0;
    int fail_cnt = 0;
    int checked_cnt = 0;
    int n_samples = 0;
    int n_nan = 0;
    int n_errors = 0;
    int n_trips = 0;
    int n_warn_chg = 0;
    int n_crit_chg = 0;
    int n_writes = 0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= LIMIT_CYCLES) begin
            $display("%0t: timeout after %0d cycles", $time, cycle_cnt);
            $display("sensor_threshold_monitor_core test failed");
            $finish;
        end
    end

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    always @(posedge i_clk) begin
        if (steady) begin
            m_ready <= 1'b1;
            rx_hold <= 0;
        end else if (rx_hold != 0) begin
            rx_hold <= rx_hold - 1;
        end else begin
            m_ready <= ($urandom_range(0, 2) != 0);
            rx_hold <= idle_len();
        end
    end

    function automatic bit alarm_next(bit cur, logic signed [VALUE_W-1:0] value,
                                      logic signed [VALUE_W-1:0] level);
        logic signed [EXT_W-1:0] v;
        logic signed [EXT_W-1:0] lv;
        logic signed [EXT_W-1:0] clr;
        v   = EXT_W'(value);
        lv  = EXT_W'(level);
        clr = lv - $signed({2'b00, trig_hyst});
        if (v >= lv) return 1'b1;
        if (v < clr) return 1'b0;
        return cur;
    endfunction

    function automatic t_result step_monitor(logic cmd, logic signed [VALUE_W-1:0] rd,
                                             logic rd_ok);
        logic signed [EXT_W-1:0] diff;
        t_result r;
        bit pub;
        bit old_w;
        bit old_c;
        pub   = 1'b0;
        old_w = warn_on;
        old_c = crit_on;
        if (cmd == CMD_SAMPLE) begin
            if (rd_ok) begin
                n_samples++;
                diff = EXT_W'(stored_val) - EXT_W'(rd);
                if (diff < 0) diff = -diff;
                if (!val_known || diff > $signed({2'b00, pub_hyst})) begin
                    stored_val = rd;
                    val_known  = 1'b1;
                    pub        = 1'b1;
                end
            end else begin
                n_nan++;
                stored_val = '0;
                val_known  = 1'b0;
                pub        = 1'b1;
            end
            if (val_known) begin
                if (alarm_en[0]) warn_on = alarm_next(warn_on, stored_val, warn_lvl);
                if (alarm_en[1]) crit_on = alarm_next(crit_on, stored_val, crit_lvl);
            end
            func_flag  = rd_ok;
            avail_flag = rd_ok;
            err_cnt    = '0;
        end else begin
            n_errors++;
            if (err_cnt < ERR_LIMIT) begin
                err_cnt = err_cnt + 1'b1;
                if (err_cnt == ERR_LIMIT) begin
                    n_trips++;
                    stored_val = '0;
                    val_known  = 1'b0;
                    pub        = 1'b1;
                    func_flag  = 1'b0;
                    avail_flag = 1'b0;
                    err_cnt    = '0;
                end
            end
        end
        if (warn_on != old_w) n_warn_chg++;
        if (crit_on != old_c) n_crit_chg++;
        r.shown_value            = val_known ? stored_val : 16'sd0;
        r.shown_valid            = val_known;
        r.value_published        = pub;
        r.warning_alarm          = warn_on;
        r.critical_alarm         = crit_on;
        r.warning_alarm_changed  = (warn_on != old_w);
        r.critical_alarm_changed = (crit_on != old_c);
        r.functional             = func_flag;
        r.available              = avail_flag;
        return r;
    endfunction

    task automatic check_field(string name, logic [VALUE_W-1:0] want_v,
                               logic [VALUE_W-1:0] got_v);
        if (got_v !== want_v) begin
            fail_cnt++;
            if (fail_cnt <= MAX_REPORTS)
                $display("%0t: %s mismatch, expected %0h, actual %0h",
                         $time, name, want_v, got_v);
        end
    endtask

    task automatic check_bit(string name, logic want_b, logic got_b);
        if (got_b !== want_b) begin
            fail_cnt++;
            if (fail_cnt <= MAX_REPORTS)
                $display("%0t: %s mismatch, expected %0b, actual %0b",
                         $time, name, want_b, got_b);
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && m_ready) begin
            res_seen = o_m_axis_tdata;
            if (pending_results.size() == 0) begin
                fail_cnt++;
                if (fail_cnt <= MAX_REPORTS)
                    $display("%0t: unexpected result word, expected none, actual %h",
                             $time, o_m_axis_tdata);
            end else begin
                res_want = pending_results.pop_front();
                checked_cnt++;
                check_field("shown_value", res_want.shown_value, res_seen.shown_value);
                check_bit("shown_valid", res_want.shown_valid, res_seen.shown_valid);
                check_bit("value_published", res_want.value_published,
                          res_seen.value_published);
                check_bit("warning_alarm", res_want.warning_alarm, res_seen.warning_alarm);
                check_bit("critical_alarm", res_want.critical_alarm,
                          res_seen.critical_alarm);
                check_bit("warning_alarm_changed", res_want.warning_alarm_changed,
                          res_seen.warning_alarm_changed);
                check_bit("critical_alarm_changed", res_want.critical_alarm_changed,
                          res_seen.critical_alarm_changed);
                check_bit("functional", res_want.functional, res_seen.functional);
                check_bit("available", res_want.available, res_seen.available);
            end
        end
    end

    task automatic send_word(logic cmd, logic signed [VALUE_W-1:0] rd, logic rd_ok);
        int gap;
        gap = steady ? 0 : idle_len();
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_valid <= 1'b1;
        s_data  <= {{(S_DATA_W-VALUE_W-1){1'b0}}, rd_ok, rd};
        s_user  <= cmd;
        do @(posedge i_clk); while (!o_s_axis_tready);
        pending_results.push_back(step_monitor(cmd, rd, rd_ok));
    endtask

    task automatic send_sample(logic signed [VALUE_W-1:0] rd);
        send_word(CMD_SAMPLE, rd, 1'b1);
    endtask

    task automatic send_nan();
        send_word(CMD_SAMPLE, 16'($urandom), 1'b0);
    endtask

    task automatic send_error();
        send_word(CMD_ERROR, 16'($urandom), 1'($urandom));
    endtask

    // drop valid, wait out every pending word and the pipeline
    task automatic settle();
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [VALUE_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        n_writes++;
        case (idx)
            CFG_WARNING_LEVEL:      warn_lvl  = val;
            CFG_CRITICAL_LEVEL:     crit_lvl  = val;
            CFG_THRESHOLD_ENABLES:  alarm_en  = val[1:0];
            CFG_TRIGGER_HYSTERESIS: trig_hyst = val;
            CFG_PUBLISH_HYSTERESIS: pub_hyst  = val;
            default: ;
        endcase
    endtask

    task automatic set_config(logic [VALUE_W-1:0] wl, logic [VALUE_W-1:0] cl,
                              logic [1:0] en, logic [VALUE_W-1:0] th,
                              logic [VALUE_W-1:0] ph);
        settle();
        write_reg(CFG_WARNING_LEVEL, wl);
        write_reg(CFG_CRITICAL_LEVEL, cl);
        write_reg(CFG_THRESHOLD_ENABLES, {14'd0, en});
        write_reg(CFG_TRIGGER_HYSTERESIS, th);
        write_reg(CFG_PUBLISH_HYSTERESIS, ph);
        cfg_valid <= 1'b0;
    endtask

    // reset configuration: alarms disabled, zero hysteresis
    task automatic test_defaults();
        send_sample(16'sh1234);
        send_sample(16'sh1234);
        send_sample(16'sh7fff);
        send_nan();
        send_error();
        send_error();
        send_sample(-16'sh8000);
    endtask

    task automatic test_alarm_hysteresis();
        set_config(16'h0100, 16'h0200, 2'b11, 16'h0080, 16'h0010);
        send_sample(16'sh0100);
        send_sample(16'sh0109);
        send_sample(16'sh0090);
        send_sample(16'sh0070);
        send_sample(16'sh0200);
        send_sample(16'sh7fff);
        send_nan();
        send_sample(-16'sh8000);
        repeat (4) send_error();
        send_error();
        send_error();
        send_sample(16'sh0180);
    endtask

    task automatic test_config_extremes();
        set_config(16'h8000, 16'h7fff, 2'b01, 16'hffff, 16'hffff);
        send_sample(16'sh7fff);
        send_sample(-16'sh8000);
        send_nan();
        send_sample(-16'sh8000);
        send_sample(16'sh7fff);
        set_config(16'h7fff, 16'h8000, 2'b10, 16'h0000, 16'h0000);
        send_sample(16'sh7fff);
        send_sample(-16'sh8000);
    endtask

    function automatic logic [VALUE_W-1:0] pick_level();
        case ($urandom_range(0, 5))
            0:       return 16'h8000;
            1:       return 16'h7fff;
            default: return 16'($urandom_range(0, 16'h4000) - 16'h2000);
        endcase
    endfunction

    function automatic logic [VALUE_W-1:0] pick_hyst(int unsigned top);
        case ($urandom_range(0, 5))
            0:       return 16'h0000;
            1:       return 16'hffff;
            default: return 16'($urandom_range(0, top));
        endcase
    endfunction

    // mostly readings around the active levels, so alarms cross both edges
    function automatic logic signed [VALUE_W-1:0] pick_reading();
        int sel;
        int base;
        int span;
        int v;
        sel  = $urandom_range(0, 9);
        span = int'(trig_hyst) + 64;
        if (sel == 0) return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
        if (sel == 1) return 16'($urandom);
        base = $urandom_range(0, 1) ? int'(warn_lvl) : int'(crit_lvl);
        v = base + int'($urandom_range(0, 2 * span)) - span;
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        return 16'(v);
    endfunction

    task automatic test_random_phase(int n, bit calm);
        int sent;
        int k;
        int burst;
        set_config(pick_level(), pick_level(), 2'($urandom), pick_hyst(16'h0400),
                   pick_hyst(16'h0100));
        steady = calm;
        sent = 0;
        while (sent < n) begin
            k = $urandom_range(0, 99);
            if (k < 6) begin
                send_nan();
                sent++;
            end else if (k < 14) begin
                burst = $urandom_range(1, 6);
                repeat (burst) send_error();
                sent += burst;
            end else begin
                send_sample(pick_reading());
                sent++;
            end
        end
        steady = 1'b0;
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_defaults();
        test_alarm_hysteresis();
        test_config_extremes();
        for (int p = 0; p < 10; p++) test_random_phase(152, (p % 3) == 2);
        settle();
        repeat (8) @(posedge i_clk);
        fail_cnt += pending_results.size();
        $display("run covered %0d samples with a reading, %0d without, %0d error events",
                 n_samples, n_nan, n_errors);
        $display("%0d results checked, %0d register writes, %0d/%0d alarm changes, %0d trips",
                 checked_cnt, n_writes, n_warn_chg, n_crit_chg, n_trips);
        if (fail_cnt == 0)
            $display("sensor_threshold_monitor_core test passed");
        else
            $display("sensor_threshold_monitor_core test failed");
        $finish;
    end

endmodule
